### rtl/irn_pkg.sv
`default_nettype none
package irn_pkg;

    localparam int ValueW = 12;
    localparam int CharW  = 7;
    localparam int NumMax = 3999;

    localparam logic [CharW-1:0] ChI    = 7'h49;
    localparam logic [CharW-1:0] ChV    = 7'h56;
    localparam logic [CharW-1:0] ChX    = 7'h58;
    localparam logic [CharW-1:0] ChL    = 7'h4C;
    localparam logic [CharW-1:0] ChC    = 7'h43;
    localparam logic [CharW-1:0] ChD    = 7'h44;
    localparam logic [CharW-1:0] ChM    = 7'h4D;
    localparam logic [CharW-1:0] ChNone = 7'h00;

    typedef logic [3:0]      t_digit;
    typedef logic [3:0][3:0] t_digits;   // index 0 = ones
    typedef logic [2:0]      t_upc;

    typedef enum logic [1:0] {SEL_U, SEL_F, SEL_T, SEL_NONE} t_sel;
    typedef enum logic [2:0] {SEQ_GOTO, SEQ_DISPATCH, SEQ_REP_LOOP, SEQ_REP_SKIP, SEQ_END} t_seq;

    typedef struct packed {
        logic emit;
        t_sel sel;
        logic err;
        t_seq seq;
        logic cnt_inc;
        t_upc target;
    } t_uword;

    typedef struct packed {
        logic             valid;
        logic [CharW-1:0] char_code;
        logic             last;
        logic             error;
    } t_emit;

    // microcode addresses
    localparam t_upc UpcRep   = 3'd0;  // unit letter, repeated
    localparam t_upc UpcUF    = 3'd1;  // unit before five
    localparam t_upc UpcFEnd  = 3'd2;  // five closing a four
    localparam t_upc UpcFRep  = 3'd3;  // five, then units
    localparam t_upc UpcUT    = 3'd4;  // unit before ten
    localparam t_upc UpcTEnd  = 3'd5;  // ten closing a nine
    localparam t_upc UpcErr   = 3'd6;  // error beat
    localparam t_upc UpcStart = 3'd7;  // split cycle, pick first digit

    function automatic t_uword urom(input t_upc a);
        t_uword w;
        case (a)
            UpcRep:   w = '{1'b1, SEL_U,    1'b0, SEQ_REP_LOOP, 1'b1, UpcRep};
            UpcUF:    w = '{1'b1, SEL_U,    1'b0, SEQ_GOTO,     1'b0, UpcFEnd};
            UpcFEnd:  w = '{1'b1, SEL_F,    1'b0, SEQ_DISPATCH, 1'b0, UpcRep};
            UpcFRep:  w = '{1'b1, SEL_F,    1'b0, SEQ_REP_SKIP, 1'b0, UpcRep};
            UpcUT:    w = '{1'b1, SEL_U,    1'b0, SEQ_GOTO,     1'b0, UpcTEnd};
            UpcTEnd:  w = '{1'b1, SEL_T,    1'b0, SEQ_DISPATCH, 1'b0, UpcRep};
            UpcErr:   w = '{1'b1, SEL_NONE, 1'b1, SEQ_END,      1'b0, UpcRep};
            UpcStart: w = '{1'b0, SEL_NONE, 1'b0, SEQ_DISPATCH, 1'b0, UpcRep};
            default:  w = '{1'b0, SEL_NONE, 1'b0, SEQ_END,      1'b0, UpcRep};
        endcase
        return w;
    endfunction

    // mapping table: digit value to entry address
    function automatic t_upc entry_of(input t_digit d);
        t_upc a;
        case (d)
            4'd4:                   a = UpcUF;
            4'd5, 4'd6, 4'd7, 4'd8: a = UpcFRep;
            4'd9:                   a = UpcUT;
            default:                a = UpcRep;
        endcase
        return a;
    endfunction

    function automatic logic [CharW-1:0] unit_letter(input logic [1:0] pos);
        logic [CharW-1:0] c;
        case (pos)
            2'd0:    c = ChI;
            2'd1:    c = ChX;
            2'd2:    c = ChC;
            default: c = ChM;
        endcase
        return c;
    endfunction

    function automatic logic [CharW-1:0] five_letter(input logic [1:0] pos);
        logic [CharW-1:0] c;
        case (pos)
            2'd0:    c = ChV;
            2'd1:    c = ChL;
            2'd2:    c = ChD;
            default: c = ChNone;
        endcase
        return c;
    endfunction

    function automatic logic [CharW-1:0] ten_letter(input logic [1:0] pos);
        logic [CharW-1:0] c;
        case (pos)
            2'd0:    c = ChX;
            2'd1:    c = ChC;
            2'd2:    c = ChM;
            default: c = ChNone;
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

### rtl/irn_split.sv
`default_nettype none
module irn_split
    import irn_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_load,
    input  wire logic [ValueW-1:0] i_value,
    output logic                   o_in_range,
    output t_digits                o_digits
);

    // reciprocal constants, exact for every 12-bit value
    localparam logic [11:0] Rcp10   = 12'd3277;  // 2^-15
    localparam logic [12:0] Rcp100  = 13'd5243;  // 2^-19
    localparam logic [13:0] Rcp1000 = 14'd8389;  // 2^-23

    logic [ValueW-1:0] r_v;
    logic [8:0]        r_q10;
    logic [5:0]        r_q100;
    logic [2:0]        r_q1000;

    logic [23:0] w_p10;
    logic [24:0] w_p100;
    logic [25:0] w_p1000;
    logic [11:0] w_r0;
    logic [8:0]  w_r1;
    logic [5:0]  w_r2;

    assign o_in_range = (i_value != '0) && (i_value <= ValueW'(NumMax));

    assign w_p10   = {12'd0, i_value} * {12'd0, Rcp10};
    assign w_p100  = {13'd0, i_value} * {12'd0, Rcp100};
    assign w_p1000 = {14'd0, i_value} * {12'd0, Rcp1000};

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_v     <= i_value;
            r_q10   <= w_p10[23:15];
            r_q100  <= w_p100[24:19];
            r_q1000 <= w_p1000[25:23];
        end
    end

    // remainders: times ten as shift-add
    assign w_r0 = r_v - ({3'd0, r_q10} << 3) - ({3'd0, r_q10} << 1);
    assign w_r1 = r_q10 - ({3'd0, r_q100} << 3) - ({3'd0, r_q100} << 1);
    assign w_r2 = r_q100 - ({3'd0, r_q1000} << 3) - ({3'd0, r_q1000} << 1);

    assign o_digits[0] = w_r0[3:0];
    assign o_digits[1] = w_r1[3:0];
    assign o_digits[2] = w_r2[3:0];
    assign o_digits[3] = {1'b0, r_q1000};

endmodule
`default_nettype wire

### rtl/irn_useq.sv
`default_nettype none
module irn_useq
    import irn_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_start,
    input  wire logic    i_in_range,
    input  wire t_digits i_digits,
    input  wire logic    i_adv,
    output t_emit        o_emit,
    output logic         o_busy
);

    logic       r_busy, n_busy;
    t_upc       r_upc,  n_upc;
    logic [2:0] r_pos,  n_pos;   // 4 means above all digits
    logic [1:0] r_cnt,  n_cnt;

    t_uword     w_word;
    t_digit     w_d;
    t_digit     w_d5;
    logic [1:0] w_rep;
    logic [1:0] w_cnt1;
    logic       w_more;
    logic [1:0] w_nxt;
    logic       w_disp;
    logic       w_fin;
    logic [CharW-1:0] w_char;

    assign w_word = urom(r_upc);
    assign w_d    = i_digits[r_pos[1:0]];
    assign w_d5   = w_d - 4'd5;
    assign w_rep  = (w_d < 4'd5) ? w_d[1:0] : w_d5[1:0];
    assign w_cnt1 = r_cnt + 2'd1;

    // highest nonzero digit below the current one
    always_comb begin
        w_more = 1'b0;
        w_nxt  = 2'd0;
        for (int k = 0; k < 4; k++) begin
            if ((3'(k) < r_pos) && (i_digits[k] != 4'd0)) begin
                w_more = 1'b1;
                w_nxt  = 2'(k);
            end
        end
    end

    always_comb begin
        w_disp = 1'b0;
        w_fin  = 1'b0;
        n_upc  = w_word.target;
        case (w_word.seq)
            SEQ_GOTO:     n_upc = w_word.target;
            SEQ_DISPATCH: w_disp = 1'b1;
            SEQ_REP_LOOP: w_disp = (w_cnt1 == w_rep);
            SEQ_REP_SKIP: w_disp = (w_rep == 2'd0);
            SEQ_END:      w_fin = 1'b1;
            default:      w_fin = 1'b1;
        endcase
        n_pos = r_pos;
        n_cnt = w_word.cnt_inc ? w_cnt1 : r_cnt;
        if (w_disp) begin
            if (w_more) begin
                n_pos = {1'b0, w_nxt};
                n_upc = entry_of(i_digits[w_nxt]);
                n_cnt = 2'd0;
            end else begin
                w_fin = 1'b1;
            end
        end
        n_busy = r_busy;
        if (r_busy && i_adv) begin
            if (w_fin) begin
                n_busy = 1'b0;
            end
        end else begin
            n_upc = r_upc;
            n_pos = r_pos;
            n_cnt = r_cnt;
        end
        if (i_start) begin
            n_busy = 1'b1;
            n_upc  = i_in_range ? UpcStart : UpcErr;
            n_pos  = 3'd4;
            n_cnt  = 2'd0;
        end
    end

    always_comb begin
        case (w_word.sel)
            SEL_U:    w_char = unit_letter(r_pos[1:0]);
            SEL_F:    w_char = five_letter(r_pos[1:0]);
            SEL_T:    w_char = ten_letter(r_pos[1:0]);
            default:  w_char = ChNone;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_upc  <= UpcStart;
            r_pos  <= 3'd4;
            r_cnt  <= 2'd0;
        end else begin
            r_busy <= n_busy;
            r_upc  <= n_upc;
            r_pos  <= n_pos;
            r_cnt  <= n_cnt;
        end
    end

    assign o_emit.valid     = r_busy && w_word.emit;
    assign o_emit.char_code = w_char;
    assign o_emit.last      = w_fin;
    assign o_emit.error     = w_word.err;
    assign o_busy           = r_busy;

endmodule
`default_nettype wire

### rtl/integer_to_roman_numeral.sv
// integer to roman numeral converter
//
// input channel: i_valid / o_stall with i_value (12 bits); a beat is taken
// when i_valid is high and o_stall is low. o_stall is high while a value is
// being converted, so one value is in flight at a time.
// output channel: o_valid / i_stall with o_char_code, o_last, o_error; one
// beat per ascii letter, most significant digit first, o_last on the final
// letter. a value of 0 or above 3999 gives a single beat with char 0,
// o_last and o_error set.
// order: the input beat registers the digit split quotients and starts the
// sequencer on its start step, which picks the first digit and issues no
// letter; each later step issues one letter into the output register, so
// letters follow one per cycle while the receiver does not stall. an error
// value goes straight to the error step, which issues its single beat.
// when the receiver stalls, the output register holds its beat and the
// sequencer freezes on its current step.
// reset (synchronous, active low) empties the output register and returns
// the sequencer to idle; no state is kept between values.
`default_nettype none
module integer_to_roman_numeral
    import irn_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire logic [ValueW-1:0] i_value,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output logic [CharW-1:0]       o_char_code,
    output logic                   o_last,
    output logic                   o_error
);

    logic    w_accept;
    logic    w_adv;
    logic    w_in_range;
    logic    w_busy;
    t_digits w_digits;
    t_emit   w_emit;

    logic             r_out_valid;
    logic [CharW-1:0] r_char_code;
    logic             r_last;
    logic             r_error;

    // take a new value only when the sequencer is idle
    assign w_accept = i_valid && !w_busy;
    // output register is free, or its beat leaves this cycle
    assign w_adv    = !r_out_valid || !i_stall;

    // digit split: quotients registered on the input beat
    irn_split u_split (
        .i_clk      (i_clk),
        .i_load     (w_accept),
        .i_value    (i_value),
        .o_in_range (w_in_range),
        .o_digits   (w_digits)
    );

    // microcode sequencer: one control word per step picks the letter
    irn_useq u_useq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_accept),
        .i_in_range (w_in_range),
        .i_digits   (w_digits),
        .i_adv      (w_adv),
        .o_emit     (w_emit),
        .o_busy     (w_busy)
    );

    // output register, control reset only
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_emit.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_char_code <= w_emit.char_code;
            r_last      <= w_emit.last;
            r_error     <= w_emit.error;
        end
    end

    assign o_stall     = w_busy;
    assign o_valid     = r_out_valid;
    assign o_char_code = r_char_code;
    assign o_last      = r_last;
    assign o_error     = r_error;

endmodule
`default_nettype wire

### sim/testbench.sv
`default_nettype none
module testbench;
    import irn_pkg::*;

    // one expected output beat: a letter, its end marker and the error flag
    typedef struct packed {
        logic [CharW-1:0] ch;
        logic             last;
        logic             err;
    } t_roman_beat;

    // letters per decimal position, index 0 = ones
    localparam logic [3:0][CharW-1:0] UnitCh = {ChM, ChC, ChX, ChI};
    localparam logic [3:0][CharW-1:0] FiveCh = {ChNone, ChD, ChL, ChV};
    localparam logic [3:0][CharW-1:0] TenCh  = {ChNone, ChM, ChC, ChX};

    // longest gaps and stalls on every value stay under a third of this
    localparam int CycleLimit = 1000000;
    // longest numeral plus the digit split cycle, with margin
    localparam int DrainCycles = 24;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_stall;
    logic [ValueW-1:0] i_value;
    logic              o_valid;
    logic              i_stall;
    logic [CharW-1:0]  o_char_code;
    logic              o_last;
    logic              o_error;

    // letters still owed by the block, oldest first
    t_roman_beat expected_letters[$];

    int  values_sent;
    int  range_errors_sent;
    int  letters_checked;
    int  mismatches;
    int  cycles;

    // idling controls, changed by the tests
    bit  send_gaps;
    bit  stall_on;
    int  stall_left;

    integer_to_roman_numeral dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_value     (i_value),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_char_code (o_char_code),
        .o_last      (o_last),
        .o_error     (o_error)
    );

    // period 4: low for 2, high for 2
    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    // mostly zero or short, now and then a long pause
    function automatic int pick_idle();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // expected letters of one value, most significant digit first
    function automatic void predict_roman(input logic [ValueW-1:0] v);
        int               n;
        int               scale;
        int               d;
        int               p;
        int               k;
        logic [CharW-1:0] letters[$];
        t_roman_beat      b;
        if (v == '0 || v > NumMax) begin
            // out of range: a single error beat with no letter
            b.ch   = ChNone;
            b.last = 1'b1;
            b.err  = 1'b1;
            expected_letters.push_back(b);
            return;
        end
        n     = int'(v);
        scale = 1000;
        for (p = 3; p >= 0; p--) begin
            d = (n / scale) % 10;
            if (d == 9) begin
                // unit before ten
                letters.push_back(UnitCh[p]);
                letters.push_back(TenCh[p]);
            end else if (d == 4) begin
                // unit before five
                letters.push_back(UnitCh[p]);
                letters.push_back(FiveCh[p]);
            end else begin
                // five first for 5..8, then the repeated units
                if (d >= 5) begin
                    letters.push_back(FiveCh[p]);
                    d = d - 5;
                end
                for (k = 0; k < d; k++)
                    letters.push_back(UnitCh[p]);
            end
            scale = scale / 10;
        end
        for (k = 0; k < letters.size(); k++) begin
            b.ch   = letters[k];
            b.last = (k == letters.size() - 1);
            b.err  = 1'b0;
            expected_letters.push_back(b);
        end
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch at cycle %0d: %s", cycles, what);
        mismatches++;
    endtask

    // drives one value at the falling edge and holds it until taken;
    // valid stays high from one beat to the next when there is no gap
    task automatic send_value(input logic [ValueW-1:0] v);
        int gap;
        gap = send_gaps ? pick_idle() : 0;
        repeat (gap) begin
            @(negedge i_clk);
            i_valid = 1'b0;
        end
        @(negedge i_clk);
        i_valid = 1'b1;
        i_value = v;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        // beat taken at this edge
        predict_roman(v);
        values_sent++;
        if (v == '0 || v > NumMax)
            range_errors_sent++;
    endtask

    // a numeral, half the time built digit by digit so that every digit shape shows up
    function automatic logic [ValueW-1:0] rand_numeral();
        int v;
        if ($urandom_range(0, 1) == 0) begin
            v = $urandom_range(0, 3) * 1000 + $urandom_range(0, 9) * 100
                + $urandom_range(0, 9) * 10 + $urandom_range(0, 9);
            if (v == 0)
                v = $urandom_range(1, 3999);
        end else begin
            v = $urandom_range(1, 3999);
        end
        return v[ValueW-1:0];
    endfunction

    // receiver stall: random runs of stall while enabled
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            i_stall = 1'b1;
            stall_left--;
        end else begin
            i_stall = 1'b0;
            if (stall_on && $urandom_range(0, 3) == 0)
                stall_left = pick_idle();
        end
    end

    // output check: each beat against the oldest expected letter
    always @(posedge i_clk) begin : roman_check
        t_roman_beat want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_letters.size() == 0) begin
                report_mismatch($sformatf("beat with nothing expected, char %h last %b err %b",
                                          o_char_code, o_last, o_error));
            end else begin
                want = expected_letters.pop_front();
                letters_checked++;
                if (o_char_code !== want.ch)
                    report_mismatch($sformatf("char_code %h, expected %h",
                                              o_char_code, want.ch));
                if (o_last !== want.last)
                    report_mismatch($sformatf("last %b, expected %b", o_last, want.last));
                if (o_error !== want.err)
                    report_mismatch($sformatf("error %b, expected %b", o_error, want.err));
            end
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CycleLimit) begin
            $display("timeout after %0d cycles, %0d letters outstanding",
                     cycles, expected_letters.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    // range edges, every digit shape, every letter, out of range values
    task automatic test_directed();
        logic [ValueW-1:0] picks[$];
        int                k;
        picks = '{12'd1, 12'd3999, 12'd0, 12'd4000, 12'd4095, 12'd3888, 12'd4,
                  12'd9, 12'd40, 12'd90, 12'd400, 12'd900, 12'd1000, 12'd2048,
                  12'd1994, 12'd444, 12'd999, 12'd5, 12'd3, 12'd8, 12'd50,
                  12'd500, 12'd10, 12'd100, 12'd2730};
        send_gaps = 1'b1;
        stall_on  = 1'b1;
        for (k = 0; k < picks.size(); k++)
            send_value(picks[k]);
    endtask

    // well-formed numerals with random idling on both sides
    task automatic test_random_numerals(input int count);
        int k;
        send_gaps = 1'b1;
        stall_on  = 1'b1;
        for (k = 0; k < count; k++)
            send_value(rand_numeral());
    endtask

    // zero and values past 3999, mixed with a few good ones
    task automatic test_out_of_range(input int count);
        int k;
        send_gaps = 1'b1;
        stall_on  = 1'b1;
        for (k = 0; k < count; k++) begin
            case ($urandom_range(0, 3))
                0:       send_value('0);
                1:       send_value(rand_numeral());
                default: send_value(ValueW'($urandom_range(NumMax + 1, 4095)));
            endcase
        end
    endtask

    // a stretch with no idling on either side
    task automatic test_back_to_back(input int count);
        int k;
        send_gaps = 1'b0;
        stall_on  = 1'b0;
        for (k = 0; k < count; k++)
            send_value(($urandom_range(0, 9) == 0) ? ValueW'($urandom_range(0, 4095))
                                                   : rand_numeral());
    endtask

    initial begin
        i_rst_n           = 1'b0;
        i_valid           = 1'b0;
        i_value           = '0;
        i_stall           = 1'b0;
        stall_left        = 0;
        send_gaps         = 1'b0;
        stall_on          = 1'b0;
        values_sent       = 0;
        range_errors_sent = 0;
        letters_checked   = 0;
        mismatches        = 0;
        cycles            = 0;

        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_random_numerals(225);
        test_back_to_back(60);
        test_out_of_range(40);
        test_random_numerals(80);

        @(negedge i_clk);
        i_valid = 1'b0;

        // drain, then let the block settle
        while (expected_letters.size() != 0)
            @(posedge i_clk);
        stall_on = 1'b0;
        repeat (DrainCycles) @(posedge i_clk);

        $display("converted %0d values (%0d out of range), %0d output beats checked",
                 values_sent, range_errors_sent, letters_checked);
        $display("%0d mismatches in %0d cycles", mismatches, cycles);
        if (mismatches == 0 && expected_letters.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
`default_nettype wire
